// ===== rtl/hss_pkg.sv =====
// hss_pkg: shared constants, request and register codes, and the blast pattern tables
// for the horn signal sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

  // field widths
  localparam int REQ_W  = 3;
  localparam int CODE_W = 3;
  localparam int PAT_W  = 3;
  localparam int MS_W   = 16;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 16;
  localparam int TBL_KIND_W = 5;
  localparam int TBL_CNT_W  = 3;

  localparam int MAX_BLASTS_DEF = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TRIGGER = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STOP    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MUTE    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UNMUTE  = 3'd4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PATTERN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTERVAL  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SHORT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_PROLONGED = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAUSE     = 3'd4;

  // periodic pattern codes
  localparam logic [PAT_W-1:0] PAT_NONE  = 3'd0;
  localparam logic [PAT_W-1:0] PAT_P     = 3'd1;
  localparam logic [PAT_W-1:0] PAT_PP    = 3'd2;
  localparam logic [PAT_W-1:0] PAT_PSS   = 3'd3;
  localparam logic [PAT_W-1:0] PAT_SPS   = 3'd4;

  // register reset values
  localparam logic [MS_W-1:0] SHORT_RST     = 16'd1000;
  localparam logic [MS_W-1:0] PROLONGED_RST = 16'd4000;
  localparam logic [MS_W-1:0] PAUSE_RST     = 16'd1000;

  // period elapsed counter: 27 bit millisecond count kept as seconds plus
  // milliseconds within the second
  localparam int PERIOD_W      = 27;
  localparam int MS_PER_S      = 1000;
  localparam int PERIOD_MAX    = (1 << PERIOD_W) - 1;
  localparam int PER_S_MAX     = PERIOD_MAX / MS_PER_S;
  localparam int PER_F_MAX     = PERIOD_MAX % MS_PER_S;
  localparam int SEC_W         = $clog2(PER_S_MAX + 1);
  localparam int FRAC_W        = $clog2(MS_PER_S);

  typedef struct packed {
    logic tick;
    logic stop;
    logic restart;
  } hss_tmr_ctl_t;

  typedef struct packed {
    logic            fire;
    logic [MS_W-1:0] countdown_s;
  } hss_tmr_sts_t;

  function automatic logic pattern_valid(input logic [PAT_W-1:0] pat);
    return (pat == PAT_P) || (pat == PAT_PP) || (pat == PAT_PSS) || (pat == PAT_SPS);
  endfunction

  // ad-hoc patterns, bit i of kinds set means blast i is prolonged
  function automatic logic [TBL_CNT_W-1:0] adhoc_count(input logic [CODE_W-1:0] code);
    logic [TBL_CNT_W-1:0] c;
    case (code)
      3'd0:    c = 3'd1;
      3'd1:    c = 3'd2;
      3'd2:    c = 3'd3;
      3'd3:    c = 3'd5;
      3'd4:    c = 3'd1;
      3'd5:    c = 3'd3;
      3'd6:    c = 3'd4;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

  function automatic logic [TBL_KIND_W-1:0] adhoc_kinds(input logic [CODE_W-1:0] code);
    logic [TBL_KIND_W-1:0] k;
    case (code)
      3'd4:    k = 5'h01;
      3'd5:    k = 5'h03;
      3'd6:    k = 5'h03;
      3'd7:    k = 5'h05;
      default: k = 5'h00;
    endcase
    return k;
  endfunction

  function automatic logic [TBL_CNT_W-1:0] per_count(input logic [PAT_W-1:0] pat);
    logic [TBL_CNT_W-1:0] c;
    case (pat)
      PAT_P:   c = 3'd1;
      PAT_PP:  c = 3'd2;
      PAT_PSS: c = 3'd3;
      PAT_SPS: c = 3'd3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [TBL_KIND_W-1:0] per_kinds(input logic [PAT_W-1:0] pat);
    logic [TBL_KIND_W-1:0] k;
    case (pat)
      PAT_P:   k = 5'h01;
      PAT_PP:  k = 5'h03;
      PAT_PSS: k = 5'h01;
      PAT_SPS: k = 5'h02;
      default: k = 5'h00;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hss_period_timer.sv =====
// hss_period_timer: periodic signal timer with saturating elapsed count,
// fire detection and whole-second countdown. Depends on hss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hss_period_timer (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire hss_pkg::hss_tmr_ctl_t    ctl,
  input  wire logic                     pat_valid,
  input  wire logic [hss_pkg::MS_W-1:0] interval_s,
  output hss_pkg::hss_tmr_sts_t         sts
);
  import hss_pkg::*;

  localparam logic [SEC_W-1:0]  S_MAX  = SEC_W'(PER_S_MAX);
  localparam logic [FRAC_W-1:0] F_MAX  = FRAC_W'(PER_F_MAX);
  localparam logic [FRAC_W-1:0] F_LAST = FRAC_W'(MS_PER_S - 1);

  logic [SEC_W-1:0]  sec_r, sec_nxt, sec_inc;
  logic [FRAC_W-1:0] frac_r, frac_nxt, frac_inc;
  logic              armed_r, armed_nxt;
  logic [SEC_W-1:0]  ival_ext;
  logic [SEC_W-1:0]  remain;
  logic              fire;

  assign ival_ext = SEC_W'(interval_s);

  // saturating millisecond increment
  always_comb begin
    sec_inc  = sec_r;
    frac_inc = frac_r;
    if (!(sec_r == S_MAX && frac_r == F_MAX)) begin
      if (frac_r == F_LAST) begin
        frac_inc = '0;
        sec_inc  = sec_r + 1'b1;
      end else begin
        frac_inc = frac_r + 1'b1;
      end
    end
  end

  // elapsed >= interval * 1000 reduces to a compare on whole seconds
  assign fire = ctl.tick && !ctl.restart && armed_r && pat_valid &&
                (interval_s != '0) && (sec_inc >= ival_ext);

  always_comb begin
    sec_nxt   = sec_r;
    frac_nxt  = frac_r;
    armed_nxt = armed_r;
    if (ctl.restart) begin
      sec_nxt   = '0;
      frac_nxt  = '0;
      armed_nxt = 1'b1;
    end else if (ctl.stop) begin
      armed_nxt = 1'b0;
    end else if (ctl.tick) begin
      if (fire) begin
        sec_nxt  = '0;
        frac_nxt = '0;
      end else begin
        sec_nxt  = sec_inc;
        frac_nxt = frac_inc;
      end
    end
  end

  // remaining whole seconds: interval - sec, less one if part of a second is gone
  always_comb begin
    remain = ival_ext - sec_nxt - SEC_W'(frac_nxt != '0);
    sts.fire = fire;
    if (!pat_valid || interval_s == '0 || sec_nxt >= ival_ext) begin
      sts.countdown_s = '0;
    end else begin
      sts.countdown_s = remain[MS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      frac_r  <= '0;
      armed_r <= 1'b0;
    end else begin
      sec_r   <= sec_nxt;
      frac_r  <= frac_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/horn_signal_sequencer.sv =====
// horn_signal_sequencer: top level, request decode, blast playback and result register.
// Depends on hss_pkg and hss_period_timer.
// The result of a word is registered and appears on the out_ channel in the cycle after it is taken.
// Throughput: one word per cycle; in_ready stays high while the result register is empty
// or is being emptied in the same cycle.
// Reset (synchronous, active low): config at its defaults, horn off, muted, periodic timer
// disarmed, result register empty.
`timescale 1ns / 1ps
`default_nettype none

module horn_signal_sequencer #(
  parameter int MAX_BLASTS = hss_pkg::MAX_BLASTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [hss_pkg::REQ_W-1:0]  in_req_type,
  input  wire logic [hss_pkg::CODE_W-1:0] in_signal_code,
  // status channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_horn_on,
  output logic                            out_busy_res,
  output logic                            out_trigger_ignored,
  output logic [hss_pkg::MS_W-1:0]        out_countdown_s,
  // config write port
  input  wire logic                       cfg_we,
  input  wire logic [hss_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [hss_pkg::DATA_W-1:0] cfg_data
);
  import hss_pkg::*;

  // blast count and index need to hold MAX_BLASTS itself
  localparam int CNT_W = $clog2(MAX_BLASTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLASTS);
  localparam logic [MS_W-1:0]  PHASE_MAX = {MS_W{1'b1}};

  // config registers
  logic [PAT_W-1:0] pattern_r;
  logic [MS_W-1:0]  interval_r;
  logic [MS_W-1:0]  short_r;
  logic [MS_W-1:0]  prolonged_r;
  logic [MS_W-1:0]  pause_r;
  logic             cfg_hit;

  // playback state
  logic [MAX_BLASTS-1:0] kinds_r, kinds_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      index_r, index_nxt;
  logic                  horn_r, horn_nxt;
  logic                  prog_r, prog_nxt;
  logic [MS_W-1:0]       phase_ms_r, phase_ms_nxt;
  logic                  muted_r, muted_nxt;
  logic                  ignored;

  // result register
  logic            out_valid_r;
  logic            out_horn_on_r;
  logic            out_busy_res_r;
  logic            out_trigger_ignored_r;
  logic [MS_W-1:0] out_countdown_s_r;

  logic         accept;
  hss_tmr_ctl_t tmr_ctl;
  hss_tmr_sts_t tmr_sts;

  // the result register frees as it drains, so a word can enter every cycle while out_ready keeps it drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // writes beyond the register list are dropped and have no side effects
  assign cfg_hit = cfg_we && ((cfg_index == REG_PATTERN) || (cfg_index == REG_INTERVAL) ||
                              (cfg_index == REG_SHORT) || (cfg_index == REG_PROLONGED) ||
                              (cfg_index == REG_PAUSE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= PAT_NONE;
      interval_r  <= '0;
      short_r     <= SHORT_RST;
      prolonged_r <= PROLONGED_RST;
      pause_r     <= PAUSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN:   pattern_r   <= cfg_data[PAT_W-1:0];
        REG_INTERVAL:  interval_r  <= cfg_data;
        REG_SHORT:     short_r     <= cfg_data;
        REG_PROLONGED: prolonged_r <= cfg_data;
        REG_PAUSE:     pause_r     <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign tmr_ctl.tick    = accept && (in_req_type == REQ_TICK);
  assign tmr_ctl.stop    = accept && (in_req_type == REQ_STOP);
  assign tmr_ctl.restart = cfg_hit;

  hss_period_timer u_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tmr_ctl),
    .pat_valid  (pattern_valid(pattern_r)),
    .interval_s (interval_r),
    .sts        (tmr_sts)
  );

  // request decode and one playback step
  always_comb begin
    logic [TBL_CNT_W-1:0]  tbl_cnt;
    logic [TBL_KIND_W-1:0] tbl_kinds;
    logic                  do_start;
    logic [CNT_W-1:0]      start_cnt;
    logic [MAX_BLASTS-1:0] kinds_shift;
    logic [MS_W-1:0]       dur;

    kinds_nxt    = kinds_r;
    count_nxt    = count_r;
    index_nxt    = index_r;
    horn_nxt     = horn_r;
    prog_nxt     = prog_r;
    phase_ms_nxt = phase_ms_r;
    muted_nxt    = muted_r;
    ignored      = 1'b0;
    do_start     = 1'b0;
    tbl_cnt      = adhoc_count(in_signal_code);
    tbl_kinds    = adhoc_kinds(in_signal_code);
    start_cnt    = '0;
    kinds_shift  = '0;
    dur          = '0;

    if (accept) begin
      case (in_req_type)
        REQ_TICK: begin
          if (phase_ms_r != PHASE_MAX) begin
            phase_ms_nxt = phase_ms_r + 1'b1;
          end
          // periodic signal restarts playback even mid-sequence
          if (tmr_sts.fire && !muted_r) begin
            tbl_cnt   = per_count(pattern_r);
            tbl_kinds = per_kinds(pattern_r);
            do_start  = 1'b1;
          end
        end
        REQ_TRIGGER: begin
          if (prog_r) begin
            ignored = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end
        REQ_STOP: begin
          horn_nxt  = 1'b0;
          prog_nxt  = 1'b0;
          index_nxt = '0;
        end
        REQ_MUTE:   muted_nxt = 1'b1;
        REQ_UNMUTE: muted_nxt = 1'b0;
        default:    ;
      endcase

      start_cnt = CNT_W'(tbl_cnt);
      if (start_cnt > CNT_MAX) begin
        start_cnt = CNT_MAX;
      end
      // an empty pattern leaves playback as it is
      if (do_start && start_cnt != '0) begin
        kinds_nxt    = MAX_BLASTS'(tbl_kinds);
        count_nxt    = start_cnt;
        index_nxt    = '0;
        prog_nxt     = 1'b1;
        horn_nxt     = 1'b1;
        phase_ms_nxt = '0;
      end

      // playback check runs only on a tick, after the periodic start
      if (in_req_type == REQ_TICK && prog_nxt) begin
        kinds_shift = kinds_nxt >> index_nxt;
        dur = kinds_shift[0] ? prolonged_r : short_r;
        if (horn_nxt) begin
          if (phase_ms_nxt >= dur) begin
            horn_nxt     = 1'b0;
            phase_ms_nxt = '0;
            // the last blast ends the sequence with no trailing pause
            if (index_nxt + 1'b1 >= count_nxt) begin
              prog_nxt  = 1'b0;
              index_nxt = '0;
            end else begin
              index_nxt = index_nxt + 1'b1;
            end
          end
        end else if (phase_ms_nxt >= pause_r) begin
          if (index_nxt >= count_nxt) begin
            prog_nxt  = 1'b0;
            index_nxt = '0;
          end else begin
            horn_nxt     = 1'b1;
            phase_ms_nxt = '0;
          end
        end
      end
    end

    // config write mutes
    if (cfg_hit) begin
      muted_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinds_r    <= '0;
      count_r    <= '0;
      index_r    <= '0;
      horn_r     <= 1'b0;
      prog_r     <= 1'b0;
      phase_ms_r <= '0;
      muted_r    <= 1'b1;
    end else begin
      kinds_r    <= kinds_nxt;
      count_r    <= count_nxt;
      index_r    <= index_nxt;
      horn_r     <= horn_nxt;
      prog_r     <= prog_nxt;
      phase_ms_r <= phase_ms_nxt;
      muted_r    <= muted_nxt;
    end
  end

  // result register: status after the word's update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_horn_on_r         <= horn_nxt;
      out_busy_res_r        <= prog_nxt;
      out_trigger_ignored_r <= ignored;
      out_countdown_s_r     <= tmr_sts.countdown_s;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_horn_on         = out_horn_on_r;
  assign out_busy_res        = out_busy_res_r;
  assign out_trigger_ignored = out_trigger_ignored_r;
  assign out_countdown_s     = out_countdown_s_r;

endmodule

`default_nettype wire

// ===== test/horn_signal_sequencer_test.sv =====
// horn_signal_sequencer_test: self-checking bench for the horn signal sequencer, driving
// request words and register writes and checking every status word against a word-by-word model.
// Depends on hss_pkg and the horn_signal_sequencer module.
`timescale 1ns / 1ps

module horn_signal_sequencer_test;
  import hss_pkg::*;

  // request and register codes the block does not use
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_UNMUTE + 1'b1;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;
  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = REG_PAUSE + 1'b1;
  localparam logic [IDX_W-1:0] REG_SPARE_LAST  = '1;

  // a few ad-hoc signal codes used by name in the directed part
  localparam logic [CODE_W-1:0] SIG_STARBOARD = 3'd0;
  localparam logic [CODE_W-1:0] SIG_DANGER    = 3'd3;
  localparam logic [CODE_W-1:0] SIG_ATTENTION = 3'd4;
  localparam logic [CODE_W-1:0] SIG_AGREEMENT = 3'd7;

  localparam logic [MS_W-1:0]     MS_FULL     = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_FULL = '1;
  localparam int                  SEQ_LIMIT   = MAX_BLASTS_DEF;

  typedef struct packed {
    logic            horn_on;
    logic            busy;
    logic            ignored;
    logic [MS_W-1:0] secs;
  } horn_status_t;

  // tracks the horn state word by word and holds the status words still to come
  class horn_status_tracker;
    logic [PAT_W-1:0]      pattern;
    logic [MS_W-1:0]       interval_s, short_ms, long_ms, gap_ms;
    logic [TBL_KIND_W-1:0] kinds;
    logic [TBL_CNT_W-1:0]  count, index;
    logic                  horn, running, muted, armed;
    logic [MS_W-1:0]       phase_ms;
    logic [PERIOD_W-1:0]   period_ms;
    logic [TBL_CNT_W-1:0]  adhoc_len[8];
    logic [TBL_KIND_W-1:0] adhoc_kind[8];
    logic [TBL_CNT_W-1:0]  cycle_len[8];
    logic [TBL_KIND_W-1:0] cycle_kind[8];
    horn_status_t          pending[$];
    int                    errors;

    function new();
      // blast count and prolonged mask (bit i = blast i prolonged) per code
      adhoc_len  = '{3'd1, 3'd2, 3'd3, 3'd5, 3'd1, 3'd3, 3'd4, 3'd4};
      adhoc_kind = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h01, 5'h03, 5'h03, 5'h05};
      cycle_len  = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0};
      cycle_kind = '{5'h00, 5'h01, 5'h03, 5'h01, 5'h02, 5'h00, 5'h00, 5'h00};
      pattern    = PAT_NONE;
      interval_s = '0;
      short_ms   = SHORT_RST;
      long_ms    = PROLONGED_RST;
      gap_ms     = PAUSE_RST;
      kinds      = '0;
      count      = '0;
      index      = '0;
      horn       = 1'b0;
      running    = 1'b0;
      muted      = 1'b1;
      armed      = 1'b0;
      phase_ms   = '0;
      period_ms  = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_PATTERN:   pattern = data[PAT_W-1:0];
        REG_INTERVAL:  interval_s = data;
        REG_SHORT:     short_ms = data;
        REG_PROLONGED: long_ms = data;
        REG_PAUSE:     gap_ms = data;
        default:       return;
      endcase
      muted     = 1'b1;
      period_ms = '0;
      armed     = 1'b1;
    endfunction

    function bit pattern_ok();
      return pattern >= PAT_P && pattern <= PAT_SPS;
    endfunction

    function logic [MS_W-1:0] secs_left();
      int unsigned ims;
      if (interval_s == 0 || !pattern_ok()) return '0;
      ims = interval_s * MS_PER_S;
      if (period_ms >= ims) return '0;
      return MS_W'((ims - period_ms) / MS_PER_S);
    endfunction

    function void launch(logic [TBL_KIND_W-1:0] mask, logic [TBL_CNT_W-1:0] len);
      logic [TBL_CNT_W-1:0] n;
      n = len;
      if (n > SEQ_LIMIT) n = TBL_CNT_W'(SEQ_LIMIT);
      if (n == 0) return;
      kinds    = mask;
      count    = n;
      index    = '0;
      running  = 1'b1;
      horn     = 1'b1;
      phase_ms = '0;
    endfunction

    function void playback();
      logic [MS_W-1:0] dur;
      if (!running) return;
      if (horn) begin
        dur = ((kinds >> index) & 1) ? long_ms : short_ms;
        if (phase_ms >= dur) begin
          horn     = 1'b0;
          phase_ms = '0;
          index    = index + 1'b1;
          // last blast: no trailing pause
          if (index >= count) begin
            running = 1'b0;
            index   = '0;
          end
        end
      end else if (phase_ms >= gap_ms) begin
        if (index >= count) begin
          running = 1'b0;
          index   = '0;
        end else begin
          horn     = 1'b1;
          phase_ms = '0;
        end
      end
    endfunction

    function void advance_ms();
      if (period_ms != PERIOD_FULL) period_ms = period_ms + 1'b1;
      if (phase_ms != MS_FULL) phase_ms = phase_ms + 1'b1;
      if (armed && pattern_ok() && interval_s != 0 && period_ms >= interval_s * MS_PER_S) begin
        if (!muted) launch(cycle_kind[pattern], cycle_len[pattern]);
        period_ms = '0;
      end
      playback();
    endfunction

    function void take_word(logic [REQ_W-1:0] req, logic [CODE_W-1:0] code);
      horn_status_t s;
      logic         dropped;
      dropped = 1'b0;
      case (req)
        REQ_TICK: advance_ms();
        REQ_TRIGGER: begin
          if (running) dropped = 1'b1;
          else launch(adhoc_kind[code], adhoc_len[code]);
        end
        REQ_STOP: begin
          horn    = 1'b0;
          running = 1'b0;
          index   = '0;
          armed   = 1'b0;
        end
        REQ_MUTE:   muted = 1'b1;
        REQ_UNMUTE: muted = 1'b0;
        default: ;
      endcase
      s.horn_on = horn;
      s.busy    = running;
      s.ignored = dropped;
      s.secs    = secs_left();
      pending.push_back(s);
    endfunction

    function void check_status(horn_status_t got);
      horn_status_t want;
      if (pending.size() == 0) begin
        $display("%0t: status word with no request outstanding", $time);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.horn_on !== want.horn_on) begin
        $display("%0t: horn_on expected %0d actual %0d", $time, want.horn_on, got.horn_on);
        errors++;
      end
      if (got.busy !== want.busy) begin
        $display("%0t: busy_res expected %0d actual %0d", $time, want.busy, got.busy);
        errors++;
      end
      if (got.ignored !== want.ignored) begin
        $display("%0t: trigger_ignored expected %0d actual %0d", $time, want.ignored,
                 got.ignored);
        errors++;
      end
      if (got.secs !== want.secs) begin
        $display("%0t: countdown_s expected %0d actual %0d", $time, want.secs, got.secs);
        errors++;
      end
    endfunction
  endclass

  // every block input is known from time zero
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type    = REQ_TICK;
  logic [CODE_W-1:0] in_signal_code = SIG_STARBOARD;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              out_horn_on;
  logic              out_busy_res;
  logic              out_trigger_ignored;
  logic [MS_W-1:0]   out_countdown_s;
  logic              cfg_we         = 1'b0;
  logic [IDX_W-1:0]  cfg_index      = REG_PATTERN;
  logic [DATA_W-1:0] cfg_data       = '0;

  horn_status_tracker board;
  bit                 quiet      = 1'b0;  // no idling on either side while set
  int                 stall_left = 0;

  always #5 clk = ~clk;

  horn_signal_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_signal_code      (in_signal_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_horn_on         (out_horn_on),
    .out_busy_res        (out_busy_res),
    .out_trigger_ignored (out_trigger_ignored),
    .out_countdown_s     (out_countdown_s),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // durations: mostly small so sequences finish, now and then an extreme
  function automatic logic [MS_W-1:0] pick_ms(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return MS_FULL;
    return MS_W'($urandom_range(lo, hi));
  endfunction

  // sample both handshakes at the rising edge; check before noting so a status
  // word can never be matched against the request taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_status({out_horn_on, out_busy_res, out_trigger_ignored, out_countdown_s});
      if (in_valid && in_ready)
        board.take_word(in_req_type, in_signal_code);
    end
  end

  // status side: ready most of the time, with random stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // one request word; valid stays up into the next word when there is no gap
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [CODE_W-1:0] code);
    int gap;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_signal_code <= code;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold off requests until every status word is back, then idle before returning
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  // pattern goes in the low bits, the rest of the word is noise
  task automatic write_pattern(input logic [PAT_W-1:0] pat);
    logic [DATA_W-1:0] d;
    d = DATA_W'($urandom);
    d[PAT_W-1:0] = pat;
    write_reg(REG_PATTERN, d);
  endtask

  // periodic: one-second interval, blasts long enough that the timer often
  // lands in the middle of a running sequence
  task automatic configure(input bit periodic);
    logic [PAT_W-1:0] pat;
    logic [MS_W-1:0]  secs;
    if (periodic) begin
      pat  = PAT_W'($urandom_range(PAT_P, PAT_SPS));
      secs = MS_W'(1);
      write_pattern(pat);
      write_reg(REG_INTERVAL, secs);
      write_reg(REG_SHORT, DATA_W'($urandom_range(30, 90)));
      write_reg(REG_PROLONGED, DATA_W'($urandom_range(80, 250)));
      write_reg(REG_PAUSE, DATA_W'($urandom_range(0, 40)));
    end else begin
      pat = PAT_W'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
        0:       secs = '0;
        1:       secs = MS_FULL;
        2:       secs = MS_W'($urandom_range(2, 300));
        default: secs = MS_W'(1);
      endcase
      write_pattern(pat);
      write_reg(REG_INTERVAL, secs);
      write_reg(REG_SHORT, pick_ms(1, 8));
      write_reg(REG_PROLONGED, pick_ms(1, 15));
      write_reg(REG_PAUSE, pick_ms(0, 6));
      // a write to an unused index must change nothing
      if ($urandom_range(0, 2) == 0)
        write_reg(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), DATA_W'($urandom));
    end
  endtask

  // periodic phases trade stop for unmute so the timer stays armed and audible
  task automatic random_word(input int tick_permille, input bit periodic);
    logic [REQ_W-1:0] req;
    int               r;
    r = $urandom_range(0, 999);
    if (r < tick_permille) begin
      req = REQ_TICK;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40)      req = REQ_TRIGGER;
      else if (r < 50) req = periodic ? REQ_UNMUTE : REQ_STOP;
      else if (r < 65) req = REQ_MUTE;
      else if (r < 88) req = REQ_UNMUTE;
      else             req = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    end
    send_word(req, CODE_W'($urandom_range(0, 7)));
  endtask

  initial begin
    int  phase;
    bit  periodic;
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: one-second short, four-second prolonged, muted, timer off
    quiet = 1'b1;
    send_word(REQ_TICK, SIG_STARBOARD);
    send_word(REQ_TRIGGER, SIG_DANGER);       // five short blasts start
    send_word(REQ_TRIGGER, SIG_AGREEMENT);    // busy, so dropped
    send_word(REQ_SPARE_FIRST, SIG_AGREEMENT);
    send_word(REQ_SPARE_LAST, SIG_STARBOARD);
    send_word(REQ_MUTE, SIG_STARBOARD);
    send_word(REQ_UNMUTE, SIG_STARBOARD);
    send_word(REQ_STOP, SIG_STARBOARD);       // horn off mid-sequence
    send_word(REQ_TICK, SIG_STARBOARD);
    drain();

    // shortest blasts, no pause, the longest interval
    quiet = 1'b0;
    write_pattern(PAT_SPS);
    write_reg(REG_INTERVAL, MS_FULL);
    write_reg(REG_SHORT, DATA_W'(1));
    write_reg(REG_PROLONGED, DATA_W'(2));
    write_reg(REG_PAUSE, '0);
    send_word(REQ_TICK, SIG_STARBOARD);       // countdown leaves its top value
    send_word(REQ_UNMUTE, SIG_STARBOARD);
    send_word(REQ_TRIGGER, SIG_AGREEMENT);    // prolonged, short, prolonged, short
    repeat (8) send_word(REQ_TICK, SIG_STARBOARD);
    send_word(REQ_TRIGGER, SIG_ATTENTION);
    repeat (3) send_word(REQ_TICK, SIG_STARBOARD);
    send_word(REQ_STOP, SIG_STARBOARD);       // timer disarmed until the next write
    drain();

    // random phases; the first holds the register extremes, one runs the periodic timer
    for (phase = 0; phase < 6; phase++) begin
      periodic = (phase == 3);
      quiet    = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        write_pattern('1);                    // unused pattern acts as none
        write_reg(REG_INTERVAL, MS_FULL);
        write_reg(REG_SHORT, '0);
        write_reg(REG_PROLONGED, MS_FULL);
        write_reg(REG_PAUSE, MS_FULL);
      end else begin
        configure(periodic);
      end
      if (periodic) begin
        send_word(REQ_UNMUTE, SIG_STARBOARD);
        repeat (1400) random_word(960, 1'b1);
      end else begin
        repeat (50) random_word(700, 1'b0);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // a hung handshake ends the run
  initial begin
    #(50_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
